// ===== rtl/core/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// Shared widths and reset values for the sliding window median unit.
// ----------------------------------------------------------------------------
package swm_pkg;

    // sample and result width in bits
    localparam int SAMPLE_W = 32;

    // window length register
    localparam int WLEN_W = 7;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd64;

    // default number of window cells
    localparam int MAX_WINDOW_DEF = 64;

endpackage
// ----------------------------------------------------------------------------

// ===== rtl/core/sliding_window_median_unit.sv =====
// Path: a sample enters the sorted cell row, then the median moves to m_tdata_reg.
// Throughput: one sample per cycle, set by the compare-and-shift update
// of the sorted cell row; back-pressure stalls s_tready only when a median is pending
// and the output register is still held.
// Reset: window length returns to 64 (clamped to MAX_WINDOW), the fill restarts and
// no result is pending; the cell row contents are don't-care until refilled.
// ----------------------------------------------------------------------------
// sliding_window_median_unit
// Running lower-median filter kept as a sorted row of cells, each with an age.
// ----------------------------------------------------------------------------
module sliding_window_median_unit
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration: window_len
    input  logic                cfg_we,
    input  logic [WLEN_W-1:0]   cfg_wdata,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,    // [31:0] sample
    // output stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata     // [31:0] median
);

    localparam int KW = $clog2(MAX_WINDOW + 1);
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int K_RESET = (int'(WLEN_RESET) > MAX_WINDOW) ? MAX_WINDOW
                           : ((WLEN_RESET == '0) ? 1 : int'(WLEN_RESET));
    localparam int MED_RESET = (K_RESET - 1) / 2;

    // sorted cell row: value and age of each held sample
    logic [SAMPLE_W-1:0] val_reg  [MAX_WINDOW];
    logic [SAMPLE_W-1:0] val_next [MAX_WINDOW];
    logic [AW-1:0]       age_reg  [MAX_WINDOW];
    logic [AW-1:0]       age_next [MAX_WINDOW];

    // control state
    logic [KW-1:0]         k_reg;
    logic [KW-1:0]         k_next;
    logic [MAX_WINDOW-1:0] med_sel_reg;
    logic [MAX_WINDOW-1:0] med_sel_next;
    logic [KW-1:0]         fill_reg;
    logic [KW-1:0]         fill_next;
    logic                  pend_reg;
    logic                  pend_next;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [SAMPLE_W-1:0]   m_tdata_reg;
    logic [SAMPLE_W-1:0]   m_tdata_next;

    logic                  accept;
    logic                  move;
    logic                  full;
    logic [KW-1:0]         nvalid;
    logic [AW-1:0]         oldest_age;
    logic [MAX_WINDOW-1:0] gt;
    logic [MAX_WINDOW-1:0] rm;
    logic [MAX_WINDOW-1:0] aft;
    logic [SAMPLE_W-1:0]   median_val;
    logic [KW-1:0]         k_wr;

    // handshake
    assign move     = pend_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !pend_reg || move;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign full       = (fill_reg >= k_reg);
    assign nvalid     = full ? k_reg : fill_reg;
    assign oldest_age = AW'(k_reg - KW'(1));

    // effective window length from a write, clamped to MAX_WINDOW, zero means one
    always_comb
    begin
        if ({25'd0, cfg_wdata} > 32'(MAX_WINDOW))
        begin
            k_wr = KW'(MAX_WINDOW);
        end
        else if (cfg_wdata == '0)
        begin
            k_wr = KW'(1);
        end
        else
        begin
            k_wr = KW'(cfg_wdata);
        end
    end

    // per-cell compare against the new sample and removal of the oldest
    always_comb
    begin
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            gt[i] = (KW'(i) < nvalid) ? (val_reg[i] > s_tdata) : 1'b1;
            rm[i] = full && (KW'(i) < k_reg) && (age_reg[i] == oldest_age);
        end
    end

    // cells past the removed one, as a log-depth prefix or
    always_comb
    begin
        logic [MAX_WINDOW-1:0] p;
        p = rm;
        for (int d = 1; d < MAX_WINDOW; d = d * 2)
        begin
            p = p | (p << d);
        end
        aft = p << 1;
    end

    // each cell takes its left or right neighbor, keeps its value, or takes the sample
    always_comb
    begin
        logic tl;
        logic tr;
        logic ts;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            tl = 1'b0;
            tr = 1'b0;
            if (i > 0)
            begin
                tl = gt[i-1] && !aft[i-1] && !rm[i-1];
            end
            if (i < MAX_WINDOW - 1)
            begin
                tr = !gt[i+1] && aft[i+1];
            end
            ts = !rm[i] && (gt[i] == aft[i]);
            if (tl)
            begin
                val_next[i] = val_reg[(i > 0) ? i - 1 : 0];
                age_next[i] = AW'(age_reg[(i > 0) ? i - 1 : 0] + AW'(1));
            end
            else if (tr)
            begin
                val_next[i] = val_reg[(i < MAX_WINDOW - 1) ? i + 1 : i];
                age_next[i] = AW'(age_reg[(i < MAX_WINDOW - 1) ? i + 1 : i] + AW'(1));
            end
            else if (ts)
            begin
                val_next[i] = val_reg[i];
                age_next[i] = AW'(age_reg[i] + AW'(1));
            end
            else
            begin
                val_next[i] = s_tdata;
                age_next[i] = '0;
            end
        end
    end

    // median tap: and-or over the one-hot select
    always_comb
    begin
        median_val = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            median_val = median_val | (val_reg[i] & {SAMPLE_W{med_sel_reg[i]}});
        end
    end

    // control next state
    always_comb
    begin
        k_next        = k_reg;
        med_sel_next  = med_sel_reg;
        fill_next     = fill_reg;
        pend_next     = pend_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        // output register
        if (move)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = median_val;
            pend_next     = 1'b0;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // sample beat
        if (accept)
        begin
            if (full)
            begin
                pend_next = 1'b1;
            end
            else
            begin
                fill_next = KW'(fill_reg + KW'(1));
                pend_next = (fill_reg == KW'(k_reg - KW'(1)));
            end
        end

        // window length write restarts the fill
        if (cfg_we)
        begin
            k_next       = k_wr;
            med_sel_next = MAX_WINDOW'(1) << AW'((k_wr - KW'(1)) >> 1);
            fill_next    = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg        <= KW'(K_RESET);
            med_sel_reg  <= MAX_WINDOW'(1) << MED_RESET;
            fill_reg     <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            k_reg        <= k_next;
            med_sel_reg  <= med_sel_next;
            fill_reg     <= fill_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        if (accept)
        begin
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                val_reg[i] <= val_next[i];
                age_reg[i] <= age_next[i];
            end
        end
    end

endmodule
// ----------------------------------------------------------------------------
